/* rtl/core/pending_request_timeout_table_core_defines.svh */
// Assertion macros for the pending request timeout table core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PENDING_REQUEST_TIMEOUT_TABLE_CORE_DEFINES_SVH
`define PENDING_REQUEST_TIMEOUT_TABLE_CORE_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define PRTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked every clock edge outside reset.
`define PRTT_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

/* rtl/core/prtt_pkg.sv */
// Shared types and constants for the pending request timeout table core.
// No dependencies; used by the interfaces, the cell and the top level.
package prtt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int DATA_W          = 32;
    localparam int TICK_W          = 8;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd5;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_WAIT = 2'd1;
    localparam logic [1:0] REQ_SEND = 2'd2;

    localparam logic CODE_OK       = 1'b0;
    localparam logic CODE_TIMEDOUT = 1'b1;

    // register index (paddr bit 2)
    localparam logic REG_TIMEOUT = 1'b0;

    // command broadcast to every cell
    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   cid;
        logic [TICK_W-1:0] timeout;
    } t_cmd;

    // token handed from cell to cell
    typedef struct packed {
        logic live;
        logic done;
    } t_tok;

    // reply event raised by the cell holding the token
    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] client;
    } t_hit;

    typedef struct packed {
        logic [ID_W-1:0]          dest_id;
        logic                     reply_code;
        logic signed [DATA_W-1:0] reply_data;
        logic                     last;
    } t_reply;

endpackage

/* rtl/core/prtt_if.sv */
// Valid/ready channel interfaces for request and reply beats.
// Depends on prtt_pkg for field widths.
interface prtt_req_if import prtt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [ID_W-1:0]          client_id;
    logic signed [DATA_W-1:0] payload;

    modport source (output valid, req_type, client_id, payload, input ready);
    modport sink   (input valid, req_type, client_id, payload, output ready);
endinterface

interface prtt_rep_if import prtt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ID_W-1:0]          dest_id;
    logic                     reply_code;
    logic signed [DATA_W-1:0] reply_data;
    logic                     last;

    modport source (output valid, dest_id, reply_code, reply_data, last, input ready);
    modport sink   (input valid, dest_id, reply_code, reply_data, last, output ready);
endinterface

/* rtl/core/pending_request_timeout_table_core.sv */
// Top level of the pending request timeout table: controller, reply buffer,
// APB register and the row of entry cells. Depends on prtt_pkg, prtt_if, prtt_cell.
//
// A table of TABLE_DEPTH waiting clients kept in a row of cells. Each accepted
// request launches a token at cell 0 that moves one cell per unstalled cycle: a wait
// claims the first free cell it passes, a send pairs with the first valid cell
// and emits two OK beats (waiting client, then sender), a tick decrements every
// valid cell and emits one timed-out beat per cell that reaches zero, in index
// order. Full-table waits, empty-table sends and request type 3 produce no
// beats. The last beat of each request has last set. A tick timed-out beat is
// held one step in a pending register so its last flag is known before it
// leaves. After its accepting edge an item keeps the input closed while its
// token walks through the cells and through a closing state; a reply beat
// due while the output register is still full stalls the walk or holds the
// close, so a new item is taken only once the last one is through. The output
// register lets the closing beat of one item wait downstream while the next
// item is accepted. timeout_ticks sits at byte address 0 (paddr[2] == 0); a
// value of 0 expires after 256 ticks.
module pending_request_timeout_table_core import prtt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    prtt_req_if.sink           i_req,
    prtt_rep_if.source         o_rep,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "pending_request_timeout_table_core_defines.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // control
    logic [1:0]               r_state, n_state;
    logic                     r_matched, n_matched;
    logic                     r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]          r_pend, n_pend;
    logic                     r_out_vld;
    t_reply                   r_out;
    logic [TICK_W-1:0]        r_timeout;

    // captured request
    logic [1:0]               r_op;
    logic [ID_W-1:0]          r_cid;
    logic signed [DATA_W-1:0] r_data;

    logic                     w_acc;
    logic                     w_adv;
    logic                     w_stall;
    logic                     w_out_free;
    logic                     w_push;
    t_reply                   w_push_rep;
    logic                     w_hit_any;
    logic [ID_W-1:0]          w_hit_client;
    logic [TABLE_DEPTH-1:0]   w_live;
    logic                     w_cfg_wr;
    t_cmd                     w_cmd;

    t_tok                     w_tok_in  [TABLE_DEPTH];
    t_tok                     w_tok_out [TABLE_DEPTH];
    t_hit                     w_hit     [TABLE_DEPTH];

    // ---------------- APB register ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
    assign prdata   = (paddr[2] == REG_TIMEOUT) ? {24'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (w_cfg_wr) begin
            r_timeout <= pwdata[TICK_W-1:0];
        end
    end

    // ---------------- cell row ----------------
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_cmd       = '{op: r_op, cid: r_cid, timeout: r_timeout};
    assign w_adv       = !w_stall;

    // token enters cell 0 on the accepting edge
    assign w_tok_in[0] = '{live: w_acc, done: 1'b0};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign w_tok_in[g] = w_tok_out[g-1];
        end
        prtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok_in[g]),
            .o_tok   (w_tok_out[g]),
            .o_hit   (w_hit[g])
        );
        assign w_live[g] = w_tok_out[g].live;
    end

    // only the token holder can raise a hit, so an AND-OR select is enough
    always_comb begin
        w_hit_any    = 1'b0;
        w_hit_client = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit_any    = w_hit_any | w_hit[i].hit;
            w_hit_client = w_hit_client | (w_hit[i].hit ? w_hit[i].client : '0);
        end
    end

    // ---------------- sequencing and reply beats ----------------
    assign w_out_free = !r_out_vld || o_rep.ready;

    always_comb begin
        n_state    = r_state;
        n_matched  = r_matched;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        w_push     = 1'b0;
        w_push_rep = '0;
        w_stall    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state   = ST_WALK;
                    n_matched = 1'b0;
                end
            end
            ST_WALK: begin
                if (w_hit_any) begin
                    if (r_op == REQ_TICK) begin
                        if (r_pend_vld) begin
                            if (w_out_free) begin
                                w_push     = 1'b1;
                                w_push_rep = '{dest_id: r_pend, reply_code: CODE_TIMEDOUT,
                                               reply_data: '0, last: 1'b0};
                                n_pend     = w_hit_client;
                            end else begin
                                w_stall = 1'b1;
                            end
                        end else begin
                            n_pend_vld = 1'b1;
                            n_pend     = w_hit_client;
                        end
                    end else begin
                        // send: waiting client's beat goes straight out
                        if (w_out_free) begin
                            w_push     = 1'b1;
                            w_push_rep = '{dest_id: w_hit_client, reply_code: CODE_OK,
                                           reply_data: r_data, last: 1'b0};
                            n_matched  = 1'b1;
                        end else begin
                            w_stall = 1'b1;
                        end
                    end
                end
                if (w_live[TABLE_DEPTH-1] && !w_stall) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_op == REQ_TICK && r_pend_vld) begin
                    if (w_out_free) begin
                        w_push     = 1'b1;
                        w_push_rep = '{dest_id: r_pend, reply_code: CODE_TIMEDOUT,
                                       reply_data: '0, last: 1'b1};
                        n_pend_vld = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end else if (r_op == REQ_SEND && r_matched) begin
                    if (w_out_free) begin
                        w_push     = 1'b1;
                        w_push_rep = '{dest_id: r_cid, reply_code: CODE_OK,
                                       reply_data: r_data, last: 1'b1};
                        n_state    = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_matched  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_matched  <= n_matched;
            r_pend_vld <= n_pend_vld;
            if (w_push) begin
                r_out_vld <= 1'b1;
            end else if (o_rep.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (w_push) begin
            r_out <= w_push_rep;
        end
        if (w_acc) begin
            r_op   <= i_req.req_type;
            r_cid  <= i_req.client_id;
            r_data <= i_req.payload;
        end
    end

    assign o_rep.valid      = r_out_vld;
    assign o_rep.dest_id    = r_out.dest_id;
    assign o_rep.reply_code = r_out.reply_code;
    assign o_rep.reply_data = r_out.reply_data;
    assign o_rep.last       = r_out.last;

    // ---------------- assertions ----------------
    `PRTT_ASSERT_ALWAYS(a_one_token, i_clk, i_rst_n, $onehot0(w_live), "two live tokens")
    `PRTT_ASSERT_IMP(a_idle_tok, i_clk, i_rst_n, i_req.ready, w_live == '0, "token in idle")
    `PRTT_ASSERT_IMP(a_idle_pend, i_clk, i_rst_n, i_req.ready, !r_pend_vld, "beat held in idle")
    `PRTT_ASSERT_IMP(a_fin_tok, i_clk, i_rst_n, r_state == ST_FIN, w_live == '0, "token in close")
    `PRTT_ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, w_stall, ##1 $stable(w_live), "moved in stall")

endmodule

/* rtl/core/prtt_cell.sv */
// One table entry: valid mark, client id, ticks left, plus the walking token.
// Depends on prtt_pkg.
module prtt_cell import prtt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_cmd i_cmd,
    input  t_tok i_tok,
    output t_tok o_tok,
    output t_hit o_hit
);

    logic              r_valid;
    logic [ID_W-1:0]   r_client;
    logic [TICK_W-1:0] r_ticks;
    t_tok              r_tok;

    logic              n_valid;
    logic [ID_W-1:0]   n_client;
    logic [TICK_W-1:0] n_ticks;
    logic              w_claim;
    logic              w_hit;

    always_comb begin
        w_claim  = 1'b0;
        w_hit    = 1'b0;
        n_valid  = r_valid;
        n_client = r_client;
        n_ticks  = r_ticks;
        if (r_tok.live) begin
            case (i_cmd.op)
                REQ_TICK: begin
                    if (r_valid) begin
                        n_ticks = r_ticks - TICK_W'(1);
                        if (r_ticks == TICK_W'(1)) begin
                            w_hit   = 1'b1;
                            n_valid = 1'b0;
                        end
                    end
                end
                REQ_WAIT: begin
                    if (!r_valid && !r_tok.done) begin
                        w_claim  = 1'b1;
                        n_valid  = 1'b1;
                        n_client = i_cmd.cid;
                        n_ticks  = i_cmd.timeout;
                    end
                end
                REQ_SEND: begin
                    if (r_valid && !r_tok.done) begin
                        w_claim = 1'b1;
                        w_hit   = 1'b1;
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    w_claim = 1'b0;
                end
            endcase
        end
    end

    assign o_tok = '{live: r_tok.live, done: r_tok.done | w_claim};
    assign o_hit = '{hit: w_hit, client: r_client};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_tok   <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_client <= n_client;
            r_ticks  <= n_ticks;
        end
    end

endmodule
